// File: rtl/core/vfhp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfhp_pkg
// shared types and constants of the video fragment header parser
// ---------------------------------------------------------------------------
package vfhp_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SHORT2,
    PH_SUBSEQ,
    PH_LEN0,
    PH_LEN1,
    PH_LEN2,
    PH_LEN3,
    PH_OFF0,
    PH_OFF1,
    PH_OFF2,
    PH_OFF3,
    PH_SEQ,
    PH_PAYLOAD
  } phase_t;

  // result beat kinds
  typedef enum logic [1:0] {
    EV_PAYLOAD,
    EV_SEGMENT,
    EV_FLUSH,
    EV_TRUNC
  } event_kind_t;

  // header byte bits 7:6
  localparam logic [1:0] HDR_SHORT    = 2'b01;
  localparam logic [1:0] HDR_MODE_END = 2'b10;
  localparam logic [1:0] HDR_MODE_TC  = 2'b11;

  localparam int LenW = 30;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic [15:0] bytes_left;
    logic        chunk_first;
    logic [31:0] chunk_timecode;
    logic        chunk_keyframe;
  } in_beat_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  payload;
    logic [29:0] seg_offset;
    logic [15:0] seg_size;
    logic [31:0] frame_time;
    logic        frame_end;
    logic        keyframe;
    logic        merged;
  } out_beat_t;

endpackage

// File: rtl/core/vfhp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfhp stream interfaces
// valid/ready channels for input bytes and result beats
// ---------------------------------------------------------------------------
interface vfhp_in_if import vfhp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vfhp_out_if import vfhp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/video_fragment_header_parser_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// video_fragment_header_parser_unit
// byte-serial sub-packet header parser: segment descriptors, payload beats,
// frame flushes and truncated header errors
// ---------------------------------------------------------------------------
// the result beat is registered: it appears in the cycle after the input beat that causes it
// throughput: one input beat per cycle; parse state updates in a single pass
//   of logic between the input port and the result register
// the result register frees each cycle it is taken, so input is stalled only
//   while a result beat waits and the sink holds ready low
// reset (rst, synchronous): parser idle, no segments held, no result pending
module video_fragment_header_parser_unit
  import vfhp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  vfhp_in_if.sink      in_ch,
  vfhp_out_if.source   out_ch
);

  // parse state
  phase_t            phase, phase_next;
  logic [7:0]        header_byte, header_byte_next;
  logic [LenW-1:0]   length_acc, length_acc_next;
  logic [LenW-1:0]   offset_acc, offset_acc_next;
  logic [15:0]       payload_remaining, payload_remaining_next;
  logic [31:0]       current_timecode, current_timecode_next;
  logic              frame_keyframe, frame_keyframe_next;
  logic              frame_merged, frame_merged_next;
  logic              segments_pending, segments_pending_next;
  logic              deliver_at_end, deliver_at_end_next;

  // result register
  logic              out_valid;
  out_beat_t         out_beat;

  logic              in_acc;
  logic              ev_valid;
  out_beat_t         ev;

  // input beat fields
  logic [7:0]        b;
  logic [15:0]       bl;
  logic [31:0]       tc;

  // header finish path
  phase_t            ph;
  logic [15:0]       room;
  logic [LenW-1:0]   fin_len, fin_off;
  logic              mode_tc, mode_end;
  logic [31:0]       diff, diff_cl;
  logic [15:0]       seg;
  logic              deliver;
  logic [29:0]       seg_off;
  logic [31:0]       this_tc;
  logic [LenW-1:0]   len_minus_off;
  logic [15:0]       rem_dec;
  logic [15:0]       acc16;
  logic              do_finish;
  logic              hdr_check;

  // a new beat goes in whenever the result register is empty or being taken
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_beat;

  assign b  = in_ch.data.in_byte;
  assign bl = in_ch.data.bytes_left;
  assign tc = in_ch.data.chunk_timecode;

  // room after the header byte; zero bytes left counts as one
  assign room = (bl == 16'd0) ? 16'd0 : bl - 16'd1;

  // segment math, valid when a header completes in this beat
  always_comb begin
    fin_len  = (phase == PH_SHORT2) ? {{(LenW-16){1'b0}}, room} : length_acc;
    fin_off  = (phase == PH_SHORT2) ? '0 : offset_acc;
    mode_tc  = (header_byte[7:6] == HDR_MODE_TC);
    mode_end = (header_byte[7:6] == HDR_MODE_END);
    len_minus_off = fin_len - fin_off;
    // offset-from-end: length minus (length minus raw) is the raw offset
    priority if (mode_end) begin
      diff = {2'b00, fin_off};
    end else if (mode_tc) begin
      diff = {2'b00, fin_len};
    end else begin
      diff = {2'b00, fin_len} - {2'b00, fin_off};
    end
    // negative fragment clamps to an empty segment
    diff_cl = diff[31] ? 32'd0 : diff;
    seg     = (diff_cl < {16'd0, room}) ? diff_cl[15:0] : room;
    deliver = header_byte[7] ||
              (({2'b00, fin_off} + {16'd0, seg}) >= {2'b00, fin_len});
    priority if (mode_tc) begin
      seg_off = '0;
    end else if (mode_end) begin
      seg_off = len_minus_off[29:0];
    end else begin
      seg_off = fin_off[29:0];
    end
    this_tc = mode_tc ? {2'b00, fin_off} : tc;
  end

  assign rem_dec = payload_remaining - 16'd1;
  assign acc16   = {length_acc[7:0], b};

  always_comb begin
    phase_next             = phase;
    header_byte_next       = header_byte;
    length_acc_next        = length_acc;
    offset_acc_next        = offset_acc;
    payload_remaining_next = payload_remaining;
    current_timecode_next  = current_timecode;
    frame_keyframe_next    = frame_keyframe;
    frame_merged_next      = frame_merged;
    segments_pending_next  = segments_pending;
    deliver_at_end_next    = deliver_at_end;
    ev_valid               = 1'b0;
    ev                     = '0;
    ev.keyframe            = frame_keyframe;
    ev.merged              = frame_merged;
    do_finish              = 1'b0;
    hdr_check              = 1'b0;
    ph                     = phase;

    // packet start: abandon partial work, maybe flush the held frame
    if (in_ch.data.chunk_first) begin
      ph                     = PH_IDLE;
      payload_remaining_next = '0;
      deliver_at_end_next    = 1'b0;
      if (!segments_pending) begin
        frame_keyframe_next = in_ch.data.chunk_keyframe;
        frame_merged_next   = 1'b0;
      end
      if (segments_pending && tc != current_timecode) begin
        ev_valid              = 1'b1;
        ev.event_kind         = EV_FLUSH;
        ev.frame_time         = current_timecode;
        ev.frame_end          = 1'b1;
        segments_pending_next = 1'b0;
      end
    end
    phase_next = ph;

    unique case (ph)
      PH_IDLE: begin
        // short tail bytes are ignored
        if (bl > 16'd2) begin
          header_byte_next = b;
          length_acc_next  = '0;
          offset_acc_next  = '0;
          priority if (b[7:6] == HDR_SHORT) begin
            phase_next = PH_SHORT2;
          end else if (!b[6]) begin
            phase_next = PH_SUBSEQ;
          end else begin
            phase_next = PH_LEN0;
          end
        end
      end
      PH_SHORT2: begin
        length_acc_next = fin_len;
        offset_acc_next = '0;
        do_finish       = 1'b1;
      end
      PH_SEQ: begin
        do_finish = 1'b1;
      end
      PH_PAYLOAD: begin
        payload_remaining_next = rem_dec;
        ev_valid               = 1'b1;
        ev.event_kind          = EV_PAYLOAD;
        ev.payload             = b;
        ev.frame_time          = current_timecode;
        if (rem_dec == 16'd0) begin
          ev.frame_end        = deliver_at_end;
          phase_next          = PH_IDLE;
          deliver_at_end_next = 1'b0;
          if (deliver_at_end) begin
            segments_pending_next = 1'b0;
            frame_keyframe_next   = 1'b0;
          end
        end
      end
      PH_SUBSEQ: begin
        phase_next = PH_LEN0;
        hdr_check  = 1'b1;
      end
      PH_LEN0: begin
        length_acc_next = {{(LenW-8){1'b0}}, b};
        phase_next      = PH_LEN1;
        hdr_check       = 1'b1;
      end
      PH_LEN1: begin
        // bit 15 marks a merged frame, bit 14 selects the 14-bit form
        if (acc16[15]) begin
          frame_merged_next = 1'b1;
        end
        if (acc16[14]) begin
          length_acc_next = {{(LenW-14){1'b0}}, acc16[13:0]};
          phase_next      = PH_OFF0;
        end else begin
          length_acc_next = {{(LenW-16){1'b0}}, acc16};
          phase_next      = PH_LEN2;
        end
        hdr_check = 1'b1;
      end
      PH_LEN2, PH_LEN3: begin
        length_acc_next = {length_acc[LenW-9:0], b};
        phase_next      = (ph == PH_LEN2) ? PH_LEN3 : PH_OFF0;
        hdr_check       = 1'b1;
      end
      PH_OFF0: begin
        offset_acc_next = {{(LenW-8){1'b0}}, b};
        phase_next      = PH_OFF1;
        hdr_check       = 1'b1;
      end
      PH_OFF1: begin
        if (offset_acc[6]) begin
          offset_acc_next = {{(LenW-14){1'b0}}, offset_acc[5:0], b};
          phase_next      = PH_SEQ;
        end else begin
          offset_acc_next = {{(LenW-16){1'b0}}, offset_acc[7:0], b};
          phase_next      = PH_OFF2;
        end
        hdr_check = 1'b1;
      end
      PH_OFF2, PH_OFF3: begin
        offset_acc_next = {offset_acc[LenW-9:0], b};
        phase_next      = (ph == PH_OFF2) ? PH_OFF3 : PH_SEQ;
        hdr_check       = 1'b1;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // header complete: emit the segment descriptor
    if (do_finish) begin
      segments_pending_next = 1'b1;
      current_timecode_next = this_tc;
      ev_valid              = 1'b1;
      ev.event_kind         = EV_SEGMENT;
      ev.seg_offset         = seg_off;
      ev.seg_size           = seg;
      ev.frame_time         = this_tc;
      if (seg == 16'd0) begin
        // empty segment returns to idle; it closes the frame on its descriptor when delivered
        ev.frame_end = deliver;
        if (deliver) begin
          segments_pending_next = 1'b0;
          frame_keyframe_next   = 1'b0;
        end
        phase_next = PH_IDLE;
      end else begin
        payload_remaining_next = seg;
        deliver_at_end_next    = deliver;
        phase_next             = PH_PAYLOAD;
      end
    end

    // header runs past the end of the packet
    if (hdr_check && bl <= 16'd1) begin
      phase_next      = PH_IDLE;
      length_acc_next = '0;
      offset_acc_next = '0;
      ev_valid        = 1'b1;
      ev              = '0;
      ev.event_kind   = EV_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      header_byte       <= '0;
      length_acc        <= '0;
      offset_acc        <= '0;
      payload_remaining <= '0;
      current_timecode  <= '0;
      frame_keyframe    <= 1'b0;
      frame_merged      <= 1'b0;
      segments_pending  <= 1'b0;
      deliver_at_end    <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (in_acc) begin
        phase             <= phase_next;
        header_byte       <= header_byte_next;
        length_acc        <= length_acc_next;
        offset_acc        <= offset_acc_next;
        payload_remaining <= payload_remaining_next;
        current_timecode  <= current_timecode_next;
        frame_keyframe    <= frame_keyframe_next;
        frame_merged      <= frame_merged_next;
        segments_pending  <= segments_pending_next;
        deliver_at_end    <= deliver_at_end_next;
        out_valid         <= ev_valid;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_beat <= ev;
    end
  end

`ifndef SYNTHESIS
  // while in the payload phase at least one byte is still owed
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_remaining != 16'd0)
    else $error("payload phase with zero bytes remaining");

  // a payload byte in mid-packet always yields a payload beat
  a_payload_beat: assert property (@(posedge clk) disable iff (rst)
    in_acc && phase == PH_PAYLOAD && !in_ch.data.chunk_first
    |=> out_valid && out_beat.event_kind == EV_PAYLOAD)
    else $error("payload byte produced no payload beat");

  // reset leaves the parser idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> phase == PH_IDLE && !out_valid && !segments_pending)
    else $error("state not cleared by reset");

  // a flush only happens when segments were held
  a_flush_held: assert property (@(posedge clk) disable iff (rst)
    in_acc && ev_valid && ev.event_kind == EV_FLUSH |-> segments_pending)
    else $error("flush with no held segments");
`endif

endmodule

// File: tb/video_fragment_header_parser_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// video_fragment_header_parser_unit_tb
// drives packets of payload bytes into the header parser and checks every
// result beat against a cycle-free model of the parse held in a scoreboard
// ---------------------------------------------------------------------------
module video_fragment_header_parser_unit_tb
  import vfhp_pkg::*;
();

  // long form header without timecode or from-end mode
  localparam logic [1:0] HDR_MODE_PLAIN = 2'b00;
  localparam int ItemsPerPhase = 634;

  // ------------------------------------------------------------------------
  // scoreboard: own copy of the parse state, expected beats in order
  // ------------------------------------------------------------------------
  class parse_scoreboard;
    phase_t      parse_ph;
    logic [7:0]  hdr;
    logic [31:0] len_acc;
    logic [31:0] off_acc;
    logic [15:0] pay_left;
    logic [31:0] cur_tc;
    logic        frm_kf;
    logic        frm_merged;
    logic        seg_held;
    logic        end_mark;
    out_beat_t   expected_beats[$];
    int          n_errors;

    function new();
      parse_ph   = PH_IDLE;
      hdr        = '0;
      len_acc    = '0;
      off_acc    = '0;
      pay_left   = '0;
      cur_tc     = '0;
      frm_kf     = 1'b0;
      frm_merged = 1'b0;
      seg_held   = 1'b0;
      end_mark   = 1'b0;
      n_errors   = 0;
    endfunction

    function out_beat_t make_beat(event_kind_t kind, logic [7:0] b, logic [31:0] off,
                                  logic [15:0] size, logic [31:0] tc, logic fend);
      out_beat_t r;
      r.event_kind = kind;
      r.payload    = b;
      r.seg_offset = off[29:0];
      r.seg_size   = size;
      r.frame_time = tc;
      r.frame_end  = fend;
      r.keyframe   = (kind == EV_TRUNC) ? 1'b0 : frm_kf;
      r.merged     = (kind == EV_TRUNC) ? 1'b0 : frm_merged;
      return r;
    endfunction

    // queue one expected beat at the back
    function void expect_beat(out_beat_t r);
      expected_beats = {expected_beats, r};
    endfunction

    // last header byte seen: work out the segment and its descriptor
    function void close_header(logic [15:0] left, logic [31:0] tc);
      logic [31:0] room, len, off, seg_tc, diff, seg, reach;
      logic        deliver;
      room   = (left > 16'd0) ? {16'd0, left} - 32'd1 : 32'd0;
      len    = len_acc;
      off    = off_acc;
      seg_tc = tc;
      if (hdr[7:6] == HDR_MODE_TC) begin
        seg_tc = off;
        off    = '0;
      end else if (hdr[7:6] == HDR_MODE_END) begin
        off = len - off;
      end
      diff = len - off;
      // negative fragment clamps to an empty segment
      if (diff[31]) diff = '0;
      seg     = (diff < room) ? diff : room;
      reach   = off + seg;
      deliver = hdr[7] || (reach >= len);
      seg_held = 1'b1;
      cur_tc   = seg_tc;
      if (seg == 32'd0) begin
        expect_beat(make_beat(EV_SEGMENT, '0, off, '0, seg_tc, deliver));
        if (deliver) begin
          seg_held = 1'b0;
          frm_kf   = 1'b0;
        end
        parse_ph = PH_IDLE;
      end else begin
        expect_beat(make_beat(EV_SEGMENT, '0, off, seg[15:0], seg_tc, 1'b0));
        pay_left = seg[15:0];
        end_mark = deliver;
        parse_ph = PH_PAYLOAD;
      end
    endfunction

    function void note_byte(in_beat_t it);
      logic [7:0]  b;
      logic [15:0] left;
      logic        mid_header;
      logic        fend;
      b          = it.in_byte;
      left       = it.bytes_left;
      mid_header = 1'b1;
      if (it.chunk_first) begin
        parse_ph = PH_IDLE;
        pay_left = '0;
        end_mark = 1'b0;
        if (!seg_held) begin
          frm_kf     = it.chunk_keyframe;
          frm_merged = 1'b0;
        end
        // new timecode while segments are held flushes the frame
        if (seg_held && it.chunk_timecode != cur_tc) begin
          expect_beat(make_beat(EV_FLUSH, '0, '0, '0, cur_tc, 1'b1));
          seg_held = 1'b0;
        end
      end
      case (parse_ph)
        PH_IDLE: begin
          mid_header = 1'b0;
          if (left > 16'd2) begin
            hdr     = b;
            len_acc = '0;
            off_acc = '0;
            if (b[7:6] == HDR_SHORT) parse_ph = PH_SHORT2;
            else if (!b[6]) parse_ph = PH_SUBSEQ;
            else parse_ph = PH_LEN0;
          end
        end
        PH_SHORT2: begin
          mid_header = 1'b0;
          len_acc    = (left > 16'd0) ? {16'd0, left} - 32'd1 : 32'd0;
          off_acc    = '0;
          close_header(left, it.chunk_timecode);
        end
        PH_SEQ: begin
          mid_header = 1'b0;
          close_header(left, it.chunk_timecode);
        end
        PH_PAYLOAD: begin
          mid_header = 1'b0;
          fend       = 1'b0;
          pay_left   = pay_left - 16'd1;
          if (pay_left == 16'd0) begin
            fend     = end_mark;
            parse_ph = PH_IDLE;
          end
          expect_beat(make_beat(EV_PAYLOAD, b, '0, '0, cur_tc, fend));
          if (fend) begin
            seg_held = 1'b0;
            frm_kf   = 1'b0;
          end
          if (pay_left == 16'd0) end_mark = 1'b0;
        end
        PH_SUBSEQ: parse_ph = PH_LEN0;
        PH_LEN0: begin
          len_acc  = {24'd0, b};
          parse_ph = PH_LEN1;
        end
        PH_LEN1: begin
          len_acc = {16'd0, len_acc[7:0], b};
          if (len_acc[15]) frm_merged = 1'b1;
          if (len_acc[14]) begin
            len_acc  = len_acc & 32'h0000_3fff;
            parse_ph = PH_OFF0;
          end else begin
            parse_ph = PH_LEN2;
          end
        end
        PH_LEN2: begin
          len_acc  = {len_acc[23:0], b};
          parse_ph = PH_LEN3;
        end
        PH_LEN3: begin
          len_acc  = {2'b00, len_acc[21:0], b};
          parse_ph = PH_OFF0;
        end
        PH_OFF0: begin
          off_acc  = {24'd0, b};
          parse_ph = PH_OFF1;
        end
        PH_OFF1: begin
          off_acc = {16'd0, off_acc[7:0], b};
          if (off_acc[14]) begin
            off_acc  = off_acc & 32'h0000_3fff;
            parse_ph = PH_SEQ;
          end else begin
            parse_ph = PH_OFF2;
          end
        end
        PH_OFF2: begin
          off_acc  = {off_acc[23:0], b};
          parse_ph = PH_OFF3;
        end
        PH_OFF3: begin
          off_acc  = {2'b00, off_acc[21:0], b};
          parse_ph = PH_SEQ;
        end
        default: begin
          mid_header = 1'b0;
          parse_ph   = PH_IDLE;
        end
      endcase
      // header cut short by the end of the packet
      if (mid_header && left <= 16'd1) begin
        parse_ph = PH_IDLE;
        len_acc  = '0;
        off_acc  = '0;
        expect_beat(make_beat(EV_TRUNC, '0, '0, '0, '0, 1'b0));
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      n_errors++;
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    endtask

    task compare_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with none expected, kind", 32'(got.event_kind), '0);
        return;
      end
      want = expected_beats.pop_front();
      compare_field("event_kind", 32'(got.event_kind), 32'(want.event_kind));
      compare_field("payload", 32'(got.payload), 32'(want.payload));
      compare_field("seg_offset", 32'(got.seg_offset), 32'(want.seg_offset));
      compare_field("seg_size", 32'(got.seg_size), 32'(want.seg_size));
      compare_field("frame_time", got.frame_time, want.frame_time);
      compare_field("frame_end", 32'(got.frame_end), 32'(want.frame_end));
      compare_field("keyframe", 32'(got.keyframe), 32'(want.keyframe));
      compare_field("merged", 32'(got.merged), 32'(want.merged));
    endtask
  endclass

  logic clk;
  logic rst;

  vfhp_in_if  in_if ();
  vfhp_out_if out_if ();

  video_fragment_header_parser_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  parse_scoreboard sb;

  // packet under construction and generator state
  logic [7:0]  pkt_q[$];
  logic [31:0] gen_tc;
  logic        gen_kf;
  bit          frame_open;
  logic [29:0] open_len;
  logic [29:0] open_off;
  int          src_idle;
  int          snk_idle;
  int          n_sent;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= snk_idle);
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_beat(out_if.data);
    end
  end

  task automatic send_item(in_beat_t it);
    while ($urandom_range(0, 99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  // sends the first count bytes of the packet, bytes_left counted from its full size
  task automatic send_packet(int count);
    in_beat_t it;
    int       total;
    total = pkt_q.size();
    for (int i = 0; i < count; i++) begin
      it.in_byte        = pkt_q[i];
      it.bytes_left     = 16'(total - i);
      it.chunk_first    = (i == 0);
      it.chunk_timecode = gen_tc;
      it.chunk_keyframe = gen_kf;
      send_item(it);
    end
  endtask

  task automatic send_noise();
    in_beat_t it;
    int       n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      it.in_byte        = 8'($urandom);
      it.bytes_left     = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 65535))
                                                      : 16'($urandom_range(1, 6));
      it.chunk_first    = (i == 0) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) == 0);
      it.chunk_timecode = ($urandom_range(0, 1) == 1) ? gen_tc : $urandom;
      it.chunk_keyframe = 1'($urandom);
      send_item(it);
    end
    frame_open = 1'b0;
  endtask

  // appends one byte to the packet under construction
  function automatic void put_byte(logic [7:0] v);
    pkt_q = {pkt_q, v};
  endfunction

  // appends one sub-packet: header in the given mode, then npay payload bytes
  function automatic void add_sub(logic [1:0] mode, logic [29:0] len, logic [29:0] offv,
                                  int npay);
    logic [7:0] hdr;
    bit         wide_len;
    bit         wide_off;
    logic       mrg;
    hdr      = 8'($urandom_range(0, 63));
    hdr[7:6] = mode;
    wide_len = ($urandom_range(0, 3) == 0) || (len > 30'h3fff);
    wide_off = ($urandom_range(0, 3) == 0) || (offv > 30'h3fff);
    mrg      = ($urandom_range(0, 5) == 0);
    put_byte(hdr);
    if (mode == HDR_SHORT) begin
      put_byte(8'($urandom));
    end else begin
      if (!mode[0]) put_byte(8'($urandom));
      if (wide_len) begin
        put_byte({mrg, 1'b0, len[29:24]});
        put_byte(len[23:16]);
        put_byte(len[15:8]);
      end else begin
        put_byte({mrg, 1'b1, len[13:8]});
      end
      put_byte(len[7:0]);
      if (wide_off) begin
        put_byte({1'($urandom), 1'b0, offv[29:24]});
        put_byte(offv[23:16]);
        put_byte(offv[15:8]);
      end else begin
        put_byte({1'($urandom), 1'b1, offv[13:8]});
      end
      put_byte(offv[7:0]);
      put_byte(8'($urandom));
    end
    repeat (npay) put_byte(8'($urandom));
  endfunction

  // one packet of well-formed sub-packets; the last may leave a frame open
  function automatic void build_frame_packet();
    int          nsub;
    int          p;
    int          kind;
    logic [29:0] base;
    logic [29:0] flen;
    bit          last;
    bit          cont;
    bit          tail_ok;
    pkt_q.delete();
    nsub    = $urandom_range(1, 3);
    cont    = frame_open && ($urandom_range(0, 99) < 75);
    tail_ok = 1'b0;
    if (!cont) begin
      frame_open = 1'b0;
      case ($urandom_range(0, 9))
        0: gen_tc = '0;
        1: gen_tc = '1;
        2: ;
        default: gen_tc = $urandom;
      endcase
      gen_kf = 1'($urandom);
    end
    for (int s = 0; s < nsub; s++) begin
      last    = (s == nsub - 1);
      tail_ok = 1'b0;
      if (s == 0 && cont) begin
        p = int'(open_len - open_off);
        if (last) p = $urandom_range(1, p);
        add_sub(HDR_MODE_PLAIN, open_len, open_off, p);
        open_off   = open_off + 30'(p);
        frame_open = (open_off != open_len);
        tail_ok    = !frame_open;
      end else begin
        base = ($urandom_range(0, 4) == 0) ? 30'($urandom_range(0, 32'h3fff_ff00))
                                           : 30'($urandom_range(0, 200));
        p    = $urandom_range(0, 16);
        kind = $urandom_range(0, 4);
        if (kind == 0 && last) begin
          add_sub(HDR_SHORT, '0, '0, p);
        end else if (kind == 3) begin
          flen = base + 30'(p);
          add_sub(HDR_MODE_END, flen, 30'(p), p);
          tail_ok = 1'b1;
        end else if (kind == 4) begin
          add_sub(HDR_MODE_TC, 30'(p), ($urandom_range(0, 1) == 1) ? 30'($urandom)
                                                                 : 30'($urandom_range(0, 99)), p);
          tail_ok = 1'b1;
        end else if (last && p >= 1 && $urandom_range(0, 2) == 0) begin
          // fragment that continues in a later packet
          flen = base + 30'(p) + 30'($urandom_range(1, 20));
          add_sub(HDR_MODE_PLAIN, flen, base, p);
          frame_open = 1'b1;
          open_len   = flen;
          open_off   = base + 30'(p);
        end else if ($urandom_range(0, 19) == 0) begin
          // offset beyond the length
          add_sub(HDR_MODE_PLAIN, base, base + 30'(p) + 30'd1, 0);
          tail_ok = 1'b1;
        end else begin
          add_sub(HDR_MODE_PLAIN, base + 30'(p), base, p);
          tail_ok = 1'b1;
        end
      end
    end
    // a byte or two left over after the last sub-packet
    if (tail_ok && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) put_byte(8'($urandom));
    end
  endfunction

  initial begin
    sb           = new();
    rst          = 1'b1;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    gen_tc       = '0;
    gen_kf       = 1'b0;
    frame_open   = 1'b0;
    open_len     = '0;
    open_off     = '0;
    src_idle     = 25;
    snk_idle     = 79;
    n_sent       = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // timecode carried in the offset, merged flag, all-ones bytes
    gen_tc = '0;
    gen_kf = 1'b1;
    pkt_q  = '{8'hff, 8'hc0, 8'h01, 8'h7f, 8'hff, 8'h00, 8'h00};
    send_packet(pkt_q.size());
    // header runs into the end of the packet
    gen_tc = 32'd5;
    pkt_q  = '{8'h00, 8'h00, 8'h00};
    send_packet(pkt_q.size());
    // fragment held for a later packet
    gen_tc = 32'd9;
    gen_kf = 1'b0;
    pkt_q  = '{8'h00, 8'h00, 8'h40, 8'h0a, 8'h40, 8'h00, 8'h00, 8'h11, 8'h22};
    send_packet(pkt_q.size());
    // new timecode flushes it, then a short tail that is ignored
    gen_tc = 32'hffff_ffff;
    pkt_q  = '{8'h12, 8'h34};
    send_packet(pkt_q.size());
    // offset past the length gives an empty segment
    gen_tc = 32'd7;
    gen_kf = 1'b1;
    pkt_q  = '{8'h3f, 8'haa, 8'h40, 8'h02, 8'hc0, 8'h05, 8'h55};
    send_packet(pkt_q.size());

    n_sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle = 25;
          snk_idle = 79;
        end
        1: begin
          src_idle = 79;
          snk_idle = 25;
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
        end
      endcase
      while (n_sent < (ph + 1) * ItemsPerPhase) begin
        case ($urandom_range(0, 9))
          0: begin
            // packet abandoned partway, next one starts while busy
            build_frame_packet();
            send_packet($urandom_range(1, pkt_q.size()));
            frame_open = 1'b0;
          end
          1: begin
            // packet cut to at most twelve bytes, which can end it inside a header
            build_frame_packet();
            begin
              int keep;
              keep = $urandom_range(1, 12);
              while (pkt_q.size() > keep) void'(pkt_q.pop_back());
            end
            send_packet(pkt_q.size());
            frame_open = 1'b0;
          end
          2: send_noise();
          default: begin
            build_frame_packet();
            send_packet(pkt_q.size());
          end
        endcase
      end
    end
    in_if.valid <= 1'b0;

    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.n_errors == 0 && sb.expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
